// ----- rtl/mhae_pkg.sv -----
package mhae_pkg;

    localparam int MAX_HARMONICS = 16;

    localparam logic [15:0] SUSTAIN_DEFAULT = 16'd1200;
    localparam logic [15:0] RELEASE_DEFAULT = 16'd80;
    localparam logic [15:0] ATTACK_FIRST    = 16'd2500;
    localparam logic [15:0] DECAY_FIRST     = 16'd400;
    localparam logic [7:0]  TYPE_FIRST      = 8'd1;
    localparam logic [15:0] AMP_FULL        = 16'd10000;

    // Sawtooth series: full amplitude divided by the harmonic number.
    localparam logic [15:0] AMP_DEFAULT [MAX_HARMONICS] = '{
        AMP_FULL / 16'd1,  AMP_FULL / 16'd2,  AMP_FULL / 16'd3,  AMP_FULL / 16'd4,
        AMP_FULL / 16'd5,  AMP_FULL / 16'd6,  AMP_FULL / 16'd7,  AMP_FULL / 16'd8,
        AMP_FULL / 16'd9,  AMP_FULL / 16'd10, AMP_FULL / 16'd11, AMP_FULL / 16'd12,
        AMP_FULL / 16'd13, AMP_FULL / 16'd14, AMP_FULL / 16'd15, AMP_FULL / 16'd16
    };

    typedef enum logic [1:0] {
        K_TICK  = 2'd0,
        K_GATE  = 2'd1,
        K_WRITE = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        S_TYPE    = 3'd0,
        S_ATTACK  = 3'd1,
        S_DECAY   = 3'd2,
        S_SUSTAIN = 3'd3,
        S_RELEASE = 3'd4,
        S_AMP     = 3'd5
    } t_setting;

    typedef enum logic [2:0] {
        PH_ATTACK  = 3'd0,
        PH_DELAY   = 3'd1,
        PH_DECAY   = 3'd2,
        PH_SUSTAIN = 3'd3,
        PH_RELEASE = 3'd4,
        PH_REVERSE = 3'd5,
        PH_OFF     = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_COUNT  = 2'd1,
        ST_UPDATE = 2'd2,
        ST_EMIT   = 2'd3
    } t_state;

    typedef struct packed {
        logic [1:0]  kind;
        logic        gate_on;
        logic [2:0]  harmonic;
        logic [2:0]  setting;
        logic [15:0] value;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  harmonic_index;
        logic [15:0] volume;
        logic [2:0]  phase;
        logic        last;
    } t_out_word;

    // Result of one cell, moved toward cell 0 during output.
    typedef struct packed {
        logic [15:0] volume;
        t_phase      phase;
    } t_cell_out;

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        logic        gate;
        logic        gate_on;
        logic        wr;
        logic [2:0]  wr_harm;
        logic [2:0]  wr_setting;
        logic [15:0] wr_value;
        logic        update;
        logic        shift;
        logic        all_done;
    } t_cell_ctrl;

endpackage

// ----- rtl/mhae_cell.sv -----
module mhae_cell #(
    parameter int CELL_IDX = 0,
    parameter int CNT_W    = 3
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mhae_pkg::t_cell_ctrl  i_ctrl,
    input  logic [CNT_W-1:0]      i_cnt,
    output logic [CNT_W-1:0]      o_cnt,
    input  mhae_pkg::t_cell_out   i_out,
    output mhae_pkg::t_cell_out   o_out
);

    logic [7:0]           r_type;
    logic [15:0]          r_att;
    logic [15:0]          r_dec;
    logic [15:0]          r_sus;
    logic [15:0]          r_rel;
    logic [15:0]          r_amp;
    logic [15:0]          r_vol;
    mhae_pkg::t_phase     r_ph;
    logic [CNT_W-1:0]     r_cnt;
    mhae_pkg::t_cell_out  r_out;

    logic [15:0]          n_vol;
    mhae_pkg::t_phase     n_ph;
    logic                 done_flag;
    logic                 sel;
    logic [16:0]          up_att;
    logic [16:0]          up_rel;
    logic [16:0]          dec_floor;

    assign done_flag = (r_type < 8'd2) && (r_amp != 16'd0) && (r_ph != mhae_pkg::PH_ATTACK);
    assign sel       = i_ctrl.wr && ({1'b0, i_ctrl.wr_harm} == 4'(CELL_IDX));
    assign up_att    = {1'b0, r_vol} + {1'b0, r_att};
    assign up_rel    = {1'b0, r_vol} + {1'b0, r_rel};
    assign dec_floor = {1'b0, r_sus} + {1'b0, r_dec};

    always_comb begin
        n_vol = r_vol;
        n_ph  = r_ph;
        if (r_amp == 16'd0) begin
            // Silent harmonics park in off and keep their last volume.
            n_ph = mhae_pkg::PH_OFF;
        end else begin
            case (r_ph)
                mhae_pkg::PH_ATTACK: begin
                    n_vol = up_att[15:0];
                    if (r_att == 16'd0 || up_att >= {1'b0, r_amp}) begin
                        n_vol = r_amp;
                        n_ph  = r_type[0] ? mhae_pkg::PH_DELAY : mhae_pkg::PH_DECAY;
                    end
                end
                mhae_pkg::PH_DELAY, mhae_pkg::PH_DECAY: begin
                    if (r_ph == mhae_pkg::PH_DECAY || i_ctrl.all_done) begin
                        n_ph  = mhae_pkg::PH_DECAY;
                        n_vol = r_vol - r_dec;
                        if (r_dec == 16'd0 || {1'b0, r_vol} <= dec_floor) begin
                            n_vol = r_sus;
                            n_ph  = (r_type == 8'd2 || r_type == 8'd3) ?
                                    mhae_pkg::PH_ATTACK : mhae_pkg::PH_SUSTAIN;
                        end
                    end
                end
                mhae_pkg::PH_SUSTAIN: begin
                    if (r_vol == 16'd0) begin
                        n_ph = mhae_pkg::PH_OFF;
                    end
                end
                mhae_pkg::PH_RELEASE: begin
                    if (r_type == 8'd4) begin
                        n_vol = up_rel[15:0];
                        if (r_rel == 16'd0 || up_rel >= {1'b0, r_amp}) begin
                            n_vol = r_amp;
                            n_ph  = mhae_pkg::PH_REVERSE;
                        end
                    end else begin
                        n_vol = r_vol - r_rel;
                        if (r_rel == 16'd0 || r_vol <= r_rel) begin
                            n_vol = 16'd0;
                            n_ph  = mhae_pkg::PH_OFF;
                        end
                    end
                end
                mhae_pkg::PH_REVERSE: begin
                    n_vol = r_vol - r_dec;
                    if (r_rel == 16'd0 || r_vol <= r_dec) begin
                        n_vol = 16'd0;
                        n_ph  = mhae_pkg::PH_OFF;
                    end
                end
                default: begin
                    n_vol = 16'd0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_type <= (CELL_IDX == 0) ? mhae_pkg::TYPE_FIRST : 8'd0;
            r_att  <= (CELL_IDX == 0) ? mhae_pkg::ATTACK_FIRST : 16'd0;
            r_dec  <= (CELL_IDX == 0) ? mhae_pkg::DECAY_FIRST : 16'd0;
            r_sus  <= mhae_pkg::SUSTAIN_DEFAULT;
            r_rel  <= mhae_pkg::RELEASE_DEFAULT;
            r_amp  <= mhae_pkg::AMP_DEFAULT[CELL_IDX];
            r_vol  <= 16'd0;
            r_ph   <= mhae_pkg::PH_RELEASE;
            r_cnt  <= '0;
        end else begin
            // The finished count ripples one cell further each cycle.
            r_cnt <= i_cnt + CNT_W'(done_flag);
            if (i_ctrl.update) begin
                r_vol <= n_vol;
                r_ph  <= n_ph;
            end else if (i_ctrl.gate) begin
                r_ph <= i_ctrl.gate_on ? mhae_pkg::PH_ATTACK : mhae_pkg::PH_RELEASE;
            end
            if (sel) begin
                case (mhae_pkg::t_setting'(i_ctrl.wr_setting))
                    mhae_pkg::S_TYPE:    r_type <= i_ctrl.wr_value[7:0];
                    mhae_pkg::S_ATTACK:  r_att  <= i_ctrl.wr_value;
                    mhae_pkg::S_DECAY:   r_dec  <= i_ctrl.wr_value;
                    mhae_pkg::S_SUSTAIN: r_sus  <= i_ctrl.wr_value;
                    mhae_pkg::S_RELEASE: r_rel  <= i_ctrl.wr_value;
                    mhae_pkg::S_AMP:     r_amp  <= i_ctrl.wr_value;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.update) begin
            r_out.volume <= n_vol;
            r_out.phase  <= n_ph;
        end else if (i_ctrl.shift) begin
            r_out <= i_out;
        end
    end

    assign o_cnt = r_cnt;
    assign o_out = r_out;

endmodule

// ----- rtl/multi_harmonic_adsr_envelope.sv -----
// Channel  | Direction | Handshake              | Word
// input    | in        | i_in_valid / o_in_stall | i_in_data  (mhae_pkg::t_in_word)
// output   | out       | o_out_valid / i_out_stall | o_out_data (mhae_pkg::t_out_word)
//
// Gate and setting writes produce no words.
// A tick runs a counting pass while the finished count ripples down the cell row,
// then an update step, then NUM_HARMONICS output words shifted out of cell 0.
// Input is stalled from a tick's acceptance until its last word is taken.
// Synchronous active-low reset loads the default sawtooth settings into every cell.
module multi_harmonic_adsr_envelope #(
    parameter int NUM_HARMONICS = 6
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  mhae_pkg::t_in_word  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output mhae_pkg::t_out_word o_out_data
);

    localparam int CNT_W = $clog2(NUM_HARMONICS + 1);
    localparam int IDX_W = (NUM_HARMONICS > 1) ? $clog2(NUM_HARMONICS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_HARMONICS - 1);

    mhae_pkg::t_state     r_state;
    mhae_pkg::t_state     n_state;
    logic [IDX_W-1:0]     r_step;
    logic [IDX_W-1:0]     n_step;

    logic                 in_acc;
    logic                 out_acc;
    mhae_pkg::t_cell_ctrl ctrl;
    logic [CNT_W-1:0]     cnt_link [NUM_HARMONICS+1];
    mhae_pkg::t_cell_out  out_link [NUM_HARMONICS+1];

    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = o_out_valid && !i_out_stall;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            mhae_pkg::ST_IDLE: begin
                n_step = '0;
                if (in_acc && mhae_pkg::t_kind'(i_in_data.kind) == mhae_pkg::K_TICK) begin
                    n_state = mhae_pkg::ST_COUNT;
                end
            end
            mhae_pkg::ST_COUNT: begin
                n_step = r_step + IDX_W'(1);
                if (r_step == LAST_IDX) begin
                    n_step  = '0;
                    n_state = mhae_pkg::ST_UPDATE;
                end
            end
            mhae_pkg::ST_UPDATE: begin
                n_step  = '0;
                n_state = mhae_pkg::ST_EMIT;
            end
            mhae_pkg::ST_EMIT: begin
                if (out_acc) begin
                    n_step = r_step + IDX_W'(1);
                    if (r_step == LAST_IDX) begin
                        n_step  = '0;
                        n_state = mhae_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = mhae_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_stall  = (r_state != mhae_pkg::ST_IDLE);
        o_out_valid = (r_state == mhae_pkg::ST_EMIT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mhae_pkg::ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        ctrl.gate       = in_acc && mhae_pkg::t_kind'(i_in_data.kind) == mhae_pkg::K_GATE;
        ctrl.gate_on    = i_in_data.gate_on;
        ctrl.wr         = in_acc && mhae_pkg::t_kind'(i_in_data.kind) == mhae_pkg::K_WRITE;
        ctrl.wr_harm    = i_in_data.harmonic;
        ctrl.wr_setting = i_in_data.setting;
        ctrl.wr_value   = i_in_data.value;
        ctrl.update     = (r_state == mhae_pkg::ST_UPDATE);
        ctrl.shift      = out_acc;
        ctrl.all_done   = (cnt_link[NUM_HARMONICS] == CNT_W'(NUM_HARMONICS));
    end

    assign cnt_link[0]             = '0;
    assign out_link[NUM_HARMONICS] = '0;

    for (genvar g = 0; g < NUM_HARMONICS; g++) begin : g_cell
        mhae_cell #(
            .CELL_IDX (g),
            .CNT_W    (CNT_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (ctrl),
            .i_cnt   (cnt_link[g]),
            .o_cnt   (cnt_link[g+1]),
            .i_out   (out_link[g+1]),
            .o_out   (out_link[g])
        );
    end

    always_comb begin
        o_out_data.harmonic_index = 3'(r_step);
        o_out_data.volume         = out_link[0].volume;
        o_out_data.phase          = out_link[0].phase;
        o_out_data.last           = (r_step == LAST_IDX);
    end

    // Input is held off for as long as a tick's words are pending.
    a_stall_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input accepted while output words pending");

    // A tick always starts the counting pass.
    a_tick_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_data.kind == mhae_pkg::K_TICK) |=> (r_state == mhae_pkg::ST_COUNT))
        else $error("tick did not start counting");

    // The final word of a tick closes the burst.
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_out_data.last) |=> !o_out_valid)
        else $error("output continued after last word");

    // Update happens exactly once, right after the count pass completes.
    a_update_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mhae_pkg::ST_UPDATE) |=> (r_state == mhae_pkg::ST_EMIT && r_step == '0))
        else $error("update not followed by output");

endmodule
